@@ hw/rtl/kcl_pkg.sv @@
// Package for the keypad code lock: payload, result and configuration types,
// event and register codes, reset values and the code digit helper.
// No dependencies.
package kcl_pkg;

    localparam int DIGIT_W    = 3;
    localparam int CODE_W     = 12;
    localparam int REG_DIGITS = 4;
    localparam int CFG_W      = 12;
    localparam int CFG_IDX_W  = 2;
    localparam int TICK_W     = 8;
    localparam int FAIL_W     = 3;
    localparam int EVENT_W    = 3;

    localparam logic [EVENT_W-1:0] EV_NONE   = 3'd0;
    localparam logic [EVENT_W-1:0] EV_ACCEPT = 3'd1;
    localparam logic [EVENT_W-1:0] EV_REJECT = 3'd2;
    localparam logic [EVENT_W-1:0] EV_WARN   = 3'd3;
    localparam logic [EVENT_W-1:0] EV_LOCK   = 3'd4;
    localparam logic [EVENT_W-1:0] EV_ADMIN  = 3'd5;
    localparam logic [EVENT_W-1:0] EV_AUTO   = 3'd6;
    localparam logic [EVENT_W-1:0] EV_IGNORE = 3'd7;

    localparam logic [CFG_IDX_W-1:0] REG_USER_CODE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OVERRIDE_CODE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LOCKDOWN_SEC  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WARNING_SEC   = 2'd3;

    localparam logic [CODE_W-1:0] USER_CODE_RST     = 12'd585;
    localparam logic [CODE_W-1:0] OVERRIDE_CODE_RST = 12'd2925;
    localparam logic [TICK_W-1:0] LOCKDOWN_SEC_RST  = 8'd60;
    localparam logic [TICK_W-1:0] WARNING_SEC_RST   = 8'd30;

    localparam logic [DIGIT_W-1:0] KEY_MAX    = 3'd5;
    localparam logic [FAIL_W-1:0]  FAIL_MAX   = 3'd7;
    localparam logic [FAIL_W-1:0]  WARN_FAILS = 3'd3;
    localparam logic [FAIL_W-1:0]  LOCK_FAILS = 3'd4;
    localparam logic [TICK_W-1:0]  TICK_MAX   = 8'hFF;

    typedef struct packed {
        logic               mode;
        logic [DIGIT_W-1:0] key;
    } item_t;

    typedef struct packed {
        logic [EVENT_W-1:0] event_res;
        logic               locked;
        logic [FAIL_W-1:0]  failures;
        logic [TICK_W-1:0]  lock_events;
        logic [1:0]         digits_held;
    } result_t;

    typedef struct packed {
        logic [CODE_W-1:0] user_code;
        logic [CODE_W-1:0] override_code;
        logic [TICK_W-1:0] lockdown_seconds;
        logic [TICK_W-1:0] warning_seconds;
    } cfg_t;

    // Digit i of a stored code; positions past the register read as zero.
    function automatic logic [DIGIT_W-1:0] code_digit(logic [CODE_W-1:0] code,
                                                      int unsigned i);
        logic [CODE_W-1:0] sh;
        sh = code >> (DIGIT_W * i);
        return (i < REG_DIGITS) ? sh[DIGIT_W-1:0] : '0;
    endfunction

endpackage

@@ hw/rtl/kcl_if.sv @@
// Valid/ready channel interfaces for the keypad code lock: key/tick items
// in, result beats out. Depends on kcl_pkg for field widths.
interface kcl_item_if;
    import kcl_pkg::*;
    logic               valid;
    logic               ready;
    logic               mode;
    logic [DIGIT_W-1:0] key;

    modport source (output valid, output mode, output key, input ready);
    modport sink   (input valid, input mode, input key, output ready);
endinterface

interface kcl_result_if;
    import kcl_pkg::*;
    logic               valid;
    logic               ready;
    logic [EVENT_W-1:0] event_res;
    logic               locked;
    logic [FAIL_W-1:0]  failures;
    logic [TICK_W-1:0]  lock_events;
    logic [1:0]         digits_held;

    modport source (output valid, output event_res, output locked, output failures,
                    output lock_events, output digits_held, input ready);
    modport sink   (input valid, input event_res, input locked, input failures,
                    input lock_events, input digits_held, output ready);
endinterface

@@ hw/rtl/kcl_core.sv @@
// Lock state and per-beat decision logic: code entry, compare, failure,
// warning hold, lockdown and tick handling. Depends on kcl_pkg.
module kcl_core #(
    parameter int CODE_LENGTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step,
    input  kcl_pkg::item_t   item,
    input  kcl_pkg::cfg_t    cfg,
    output kcl_pkg::result_t res
);
    import kcl_pkg::*;

    localparam int PW = (CODE_LENGTH > 1) ? $clog2(CODE_LENGTH) : 1;
    localparam logic [PW-1:0] POS_LAST = PW'(CODE_LENGTH - 1);

    logic [DIGIT_W-1:0] entry_reg [CODE_LENGTH];
    logic [PW-1:0]      pos_reg, pos_next;
    logic [FAIL_W-1:0]  fail_reg, fail_next;
    logic               lock_reg, lock_next;
    logic [TICK_W-1:0]  lticks_reg, lticks_next;
    logic [TICK_W-1:0]  wticks_reg, wticks_next;
    logic [TICK_W-1:0]  events_reg, events_next;

    logic               store;
    logic               user_ok;
    logic               override_ok;
    logic [TICK_W-1:0]  lticks_inc;
    logic [FAIL_W-1:0]  fail_inc;
    logic [EVENT_W-1:0] ev;
    logic [PW+1:0]      pos_ext;

    always_comb
    begin
        logic [DIGIT_W-1:0] d;
        user_ok     = 1'b1;
        override_ok = 1'b1;
        for (int i = 0; i < CODE_LENGTH; i++)
        begin
            d = (i == CODE_LENGTH - 1) ? item.key : entry_reg[i];
            if (d != code_digit(cfg.user_code, i))
                user_ok = 1'b0;
            if (d != code_digit(cfg.override_code, i))
                override_ok = 1'b0;
        end
    end

    assign lticks_inc = (lticks_reg != TICK_MAX) ? lticks_reg + 1'b1 : lticks_reg;
    assign fail_inc   = (fail_reg != FAIL_MAX) ? fail_reg + 1'b1 : fail_reg;

    always_comb
    begin
        pos_next    = pos_reg;
        fail_next   = fail_reg;
        lock_next   = lock_reg;
        lticks_next = lticks_reg;
        wticks_next = wticks_reg;
        events_next = events_reg;
        store       = 1'b0;
        ev          = EV_NONE;
        if (item.mode)
        begin
            if (lock_reg)
            begin
                lticks_next = lticks_inc;
                if (lticks_inc >= cfg.lockdown_seconds)
                begin
                    lock_next   = 1'b0;
                    lticks_next = '0;
                    fail_next   = '0;
                    ev          = EV_AUTO;
                end
            end
            else if (wticks_reg != '0)
            begin
                wticks_next = wticks_reg - 1'b1;
            end
        end
        else if (item.key > KEY_MAX || (!lock_reg && wticks_reg != '0))
        begin
            ev = EV_IGNORE;
        end
        else
        begin
            store = 1'b1;
            if (pos_reg == POS_LAST)
            begin
                pos_next = '0;
                if (lock_reg)
                begin
                    if (override_ok)
                    begin
                        lock_next   = 1'b0;
                        lticks_next = '0;
                        fail_next   = '0;
                        ev          = EV_ADMIN;
                    end
                    else
                    begin
                        ev = EV_REJECT;
                    end
                end
                else if (user_ok)
                begin
                    fail_next = '0;
                    ev        = EV_ACCEPT;
                end
                else
                begin
                    fail_next = fail_inc;
                    if (fail_inc == WARN_FAILS)
                    begin
                        wticks_next = cfg.warning_seconds;
                        ev          = EV_WARN;
                    end
                    else if (fail_inc >= LOCK_FAILS)
                    begin
                        lock_next   = 1'b1;
                        lticks_next = '0;
                        if (events_reg != TICK_MAX)
                            events_next = events_reg + 1'b1;
                        ev          = EV_LOCK;
                    end
                    else
                    begin
                        ev = EV_REJECT;
                    end
                end
            end
            else
            begin
                pos_next = pos_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            fail_reg   <= '0;
            lock_reg   <= 1'b0;
            lticks_reg <= '0;
            wticks_reg <= '0;
            events_reg <= '0;
        end
        else if (step)
        begin
            pos_reg    <= pos_next;
            fail_reg   <= fail_next;
            lock_reg   <= lock_next;
            lticks_reg <= lticks_next;
            wticks_reg <= wticks_next;
            events_reg <= events_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step && store)
            entry_reg[pos_reg] <= item.key;
    end

    assign pos_ext = {2'b00, pos_next};

    always_comb
    begin
        res.event_res   = ev;
        res.locked      = lock_next;
        res.failures    = fail_next;
        res.lock_events = events_next;
        res.digits_held = pos_ext[1:0];
    end

endmodule

@@ hw/rtl/keypad_code_lock_lockout.sv @@
// Top level of the keypad code lock: configuration registers, input beat
// register and result register around kcl_core. Depends on kcl_pkg, kcl_if.
//
// Usage:
//   item   : valid/ready channel of key presses (mode 0, key 0..5) and
//            one-second ticks (mode 1). Every accepted beat gives one result.
//   result : valid/ready channel carrying the event code and the lock state
//            after the beat (locked, failures, lock_events, digits_held).
//   wr_*   : register write port (user code, override code, lockdown ticks,
//            warning ticks); write only while no beat is in flight.
// Path: an accepted beat waits in the input register, and its result in the result register.
// Throughput: one beat per cycle; the input register hands over to the
//   result register in the same cycle the result is taken, so item.ready
//   stays high while the downstream side keeps up.
// Stall: while result is held, one more beat may wait in the input register;
//   item.ready then drops until the result beat leaves.
// Reset: registers return to their default codes and times, the lock opens,
//   counters clear and both beat registers empty.
module keypad_code_lock_lockout #(
    parameter int CODE_LENGTH = 4
) (
    input  logic                            clk,
    input  logic                            rst_n,
    kcl_item_if.sink                        item,
    kcl_result_if.source                    result,
    input  logic                            wr_en,
    input  logic [kcl_pkg::CFG_IDX_W-1:0]   wr_index,
    input  logic [kcl_pkg::CFG_W-1:0]       wr_data
);
    import kcl_pkg::*;

    cfg_t    cfg_reg;
    logic    in_valid_reg;
    item_t   in_item_reg;
    logic    out_valid_reg;
    result_t out_res_reg;
    result_t core_res;
    logic    advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.user_code        <= USER_CODE_RST;
            cfg_reg.override_code    <= OVERRIDE_CODE_RST;
            cfg_reg.lockdown_seconds <= LOCKDOWN_SEC_RST;
            cfg_reg.warning_seconds  <= WARNING_SEC_RST;
        end
        else if (wr_en)
        begin
            case (wr_index)
                REG_USER_CODE:     cfg_reg.user_code        <= wr_data;
                REG_OVERRIDE_CODE: cfg_reg.override_code    <= wr_data;
                REG_LOCKDOWN_SEC:  cfg_reg.lockdown_seconds <= wr_data[TICK_W-1:0];
                REG_WARNING_SEC:   cfg_reg.warning_seconds  <= wr_data[TICK_W-1:0];
                default:           cfg_reg                  <= cfg_reg;
            endcase
        end
    end

    assign advance    = in_valid_reg && (!out_valid_reg || result.ready);
    assign item.ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (item.ready)
                in_valid_reg <= item.valid;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (result.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item.valid && item.ready)
        begin
            in_item_reg.mode <= item.mode;
            in_item_reg.key  <= item.key;
        end
        if (advance)
            out_res_reg <= core_res;
    end

    kcl_core #(
        .CODE_LENGTH (CODE_LENGTH)
    ) u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (advance),
        .item  (in_item_reg),
        .cfg   (cfg_reg),
        .res   (core_res)
    );

    assign result.valid       = out_valid_reg;
    assign result.event_res   = out_res_reg.event_res;
    assign result.locked      = out_res_reg.locked;
    assign result.failures    = out_res_reg.failures;
    assign result.lock_events = out_res_reg.lock_events;
    assign result.digits_held = out_res_reg.digits_held;

endmodule

@@ hw/rtl/kcl_checker.sv @@
// Port-level checks for the keypad code lock, bound to the top level.
// Depends on kcl_pkg and keypad_code_lock_lockout.
module kcl_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          res_valid,
    input logic                          res_ready,
    input logic [kcl_pkg::EVENT_W-1:0]   event_res,
    input logic                          locked,
    input logic [kcl_pkg::FAIL_W-1:0]    failures,
    input logic [kcl_pkg::TICK_W-1:0]    lock_events,
    input logic [1:0]                    digits_held
);
    import kcl_pkg::*;

    a_locked_at_four: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && locked |-> failures == LOCK_FAILS)
        else $error("locked with failure count other than four");

    a_lock_event: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && event_res == EV_LOCK |-> locked && lock_events != '0
                                             && digits_held == '0)
        else $error("lockdown beat without lock state");

    a_unlock_clears: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (event_res == EV_ADMIN || event_res == EV_AUTO
                      || event_res == EV_ACCEPT) |-> !locked && failures == '0)
        else $error("unlock or accept left failures or lock set");

    a_unlocked_bound: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !locked |-> failures < LOCK_FAILS)
        else $error("failure count too high while unlocked");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(event_res)
                                    && $stable(lock_events))
        else $error("stalled result beat changed");

endmodule

bind keypad_code_lock_lockout kcl_checker u_kcl_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .res_valid   (result.valid),
    .res_ready   (result.ready),
    .event_res   (result.event_res),
    .locked      (result.locked),
    .failures    (result.failures),
    .lock_events (result.lock_events),
    .digits_held (result.digits_held)
);

@@ tb/sv/keypad_code_lock_lockout_tb.sv @@
// Self-checking testbench for keypad_code_lock_lockout: key and tick beats in,
// lock status beats out, each compared with a cycle-free model of the lock.
// Depends on kcl_pkg, keypad_code_lock_lockout and the kcl_item_if / kcl_result_if interfaces.
`timescale 1ns / 100ps

module keypad_code_lock_lockout_tb;
    import kcl_pkg::*;

    localparam int CODE_LEN = 4;

    logic                 clk;
    logic                 rst_n;
    logic                 wr_en;
    logic [CFG_IDX_W-1:0] wr_index;
    logic [CFG_W-1:0]     wr_data;

    kcl_item_if   item_ch ();
    kcl_result_if result_ch ();

    keypad_code_lock_lockout #(.CODE_LENGTH(CODE_LEN)) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .item     (item_ch),
        .result   (result_ch),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data)
    );

    // lock model
    cfg_t               lock_cfg;
    logic [DIGIT_W-1:0] entry [CODE_LEN];
    int unsigned        entry_pos;
    logic [FAIL_W-1:0]  fail_cnt;
    logic               model_locked;
    logic [TICK_W-1:0]  lock_age;
    logic [TICK_W-1:0]  warn_left;
    logic [TICK_W-1:0]  lockdowns;

    result_t     status_due [$];
    int          mismatches;
    int          useful_beats;
    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic cfg_t make_config(input logic [CODE_W-1:0] user,
                                         input logic [CODE_W-1:0] admin,
                                         input logic [TICK_W-1:0] lockdown,
                                         input logic [TICK_W-1:0] warning);
        cfg_t c;
        c.user_code        = user;
        c.override_code    = admin;
        c.lockdown_seconds = lockdown;
        c.warning_seconds  = warning;
        return c;
    endfunction

    function automatic logic [DIGIT_W-1:0] pick_key(input bit any_key);
        int unsigned r;
        r = any_key ? $urandom : $urandom_range(KEY_MAX);
        return r[DIGIT_W-1:0];
    endfunction

    function automatic logic [CODE_W-1:0] rand_code(input bit any_digit);
        logic [CODE_W-1:0] c;
        for (int i = 0; i < REG_DIGITS; i++)
            c[DIGIT_W*i +: DIGIT_W] = pick_key(any_digit && $urandom_range(7) == 0);
        return c;
    endfunction

    function automatic cfg_t rand_config();
        int unsigned lockdown;
        int unsigned warning;
        lockdown = ($urandom_range(9) == 0) ? 1 : $urandom_range(2, 12);
        warning  = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 6);
        return make_config(rand_code(1'b1), rand_code(1'b1), lockdown[TICK_W-1:0],
                           warning[TICK_W-1:0]);
    endfunction

    function automatic bit entry_is(input logic [CODE_W-1:0] code);
        logic [DIGIT_W-1:0] want;
        for (int i = 0; i < CODE_LEN; i++)
        begin
            want = (i < REG_DIGITS) ? code[DIGIT_W*i +: DIGIT_W] : '0;
            if (entry[i] != want)
                return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic logic [EVENT_W-1:0] close_entry();
        if (model_locked)
        begin
            if (entry_is(lock_cfg.override_code))
            begin
                model_locked = 1'b0;
                lock_age     = '0;
                fail_cnt     = '0;
                return EV_ADMIN;
            end
            return EV_REJECT;
        end
        if (entry_is(lock_cfg.user_code))
        begin
            fail_cnt = '0;
            return EV_ACCEPT;
        end
        if (fail_cnt < FAIL_MAX)
            fail_cnt = fail_cnt + 1'b1;
        if (fail_cnt == WARN_FAILS)
        begin
            warn_left = lock_cfg.warning_seconds;
            return EV_WARN;
        end
        if (fail_cnt >= LOCK_FAILS)
        begin
            model_locked = 1'b1;
            lock_age     = '0;
            if (lockdowns != TICK_MAX)
                lockdowns = lockdowns + 1'b1;
            return EV_LOCK;
        end
        return EV_REJECT;
    endfunction

    function automatic result_t predict_status(input logic mode,
                                               input logic [DIGIT_W-1:0] key);
        result_t r;
        r.event_res = EV_NONE;
        if (mode)
        begin
            if (model_locked)
            begin
                if (lock_age != TICK_MAX)
                    lock_age = lock_age + 1'b1;
                if (lock_age >= lock_cfg.lockdown_seconds)
                begin
                    model_locked = 1'b0;
                    lock_age     = '0;
                    fail_cnt     = '0;
                    r.event_res  = EV_AUTO;
                end
            end
            else if (warn_left != 0)
                warn_left = warn_left - 1'b1;
        end
        else if (key > KEY_MAX || (!model_locked && warn_left != 0))
            r.event_res = EV_IGNORE;
        else
        begin
            entry[entry_pos] = key;
            if (entry_pos + 1 >= CODE_LEN)
            begin
                entry_pos   = 0;
                r.event_res = close_entry();
            end
            else
                entry_pos = entry_pos + 1;
        end
        r.locked      = model_locked;
        r.failures    = fail_cnt;
        r.lock_events = lockdowns;
        r.digits_held = entry_pos[1:0];
        return r;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    task automatic send_beat(input logic mode, input logic [DIGIT_W-1:0] key);
        result_t due;
        while ($urandom_range(99) < send_idle_pct)
        begin
            item_ch.valid <= 1'b0;
            @(posedge clk);
        end
        item_ch.valid <= 1'b1;
        item_ch.mode  <= mode;
        item_ch.key   <= key;
        do @(posedge clk); while (!item_ch.ready);
        due = predict_status(mode, key);
        status_due.push_back(due);
        if (due.event_res != EV_IGNORE)
            useful_beats++;
    endtask

    task automatic send_tick();
        send_beat(1'b1, pick_key(1'b1));
    endtask

    // complete any partial code with random digits, then key in the code
    task automatic enter_code(input logic [CODE_W-1:0] code);
        int unsigned fill;
        fill = (CODE_LEN - entry_pos) % CODE_LEN;
        repeat (fill) send_beat(1'b0, pick_key(1'b0));
        for (int i = 0; i < REG_DIGITS; i++)
            send_beat(1'b0, code[DIGIT_W*i +: DIGIT_W]);
    endtask

    task automatic drain_results();
        item_ch.valid <= 1'b0;
        do @(posedge clk); while (status_due.size() != 0);
    endtask

    task automatic write_config(input cfg_t next);
        drain_results();
        wr_en    <= 1'b1;
        wr_index <= REG_USER_CODE;
        wr_data  <= next.user_code;
        @(posedge clk);
        wr_index <= REG_OVERRIDE_CODE;
        wr_data  <= next.override_code;
        @(posedge clk);
        wr_index <= REG_LOCKDOWN_SEC;
        wr_data  <= {{(CFG_W-TICK_W){1'b0}}, next.lockdown_seconds};
        @(posedge clk);
        wr_index <= REG_WARNING_SEC;
        wr_data  <= {{(CFG_W-TICK_W){1'b0}}, next.warning_seconds};
        @(posedge clk);
        wr_en    <= 1'b0;
        lock_cfg = next;
    endtask

    // tick out any lockdown and warning hold
    task automatic settle_lock();
        while (model_locked || warn_left != 0)
            send_tick();
    endtask

    task automatic test_default_codes();
        enter_code(USER_CODE_RST);
        enter_code(OVERRIDE_CODE_RST);
        send_beat(1'b0, 3'd7);
        send_beat(1'b0, 3'd6);
        send_tick();
    endtask

    task automatic test_warning_hold();
        write_config(make_config(12'o0000, 12'o5050, 8'd2, 8'd1));
        enter_code(12'o1234);
        enter_code(12'o5432);
        send_beat(1'b0, 3'd0);
        send_tick();
    endtask

    task automatic test_lockdown();
        enter_code(12'o0001);
        enter_code(12'o0000);
        enter_code(12'o5050);
    endtask

    task automatic test_zero_hold();
        write_config(make_config(12'o0000, 12'o5050, 8'd0, 8'd0));
        repeat (3) enter_code(12'o3333);
        enter_code(12'o4444);
        send_beat(1'b0, 3'd1);
        send_beat(1'b0, 3'd2);
        send_tick();
        send_beat(1'b0, 3'd3);
        send_beat(1'b0, 3'd4);
    endtask

    task automatic test_longest_hold();
        settle_lock();
        write_config(make_config(12'o0000, 12'o5555, TICK_MAX, TICK_MAX));
        enter_code(12'o0000);
        while (!model_locked)
        begin
            if (warn_left != 0)
                send_tick();
            else
                enter_code(rand_code(1'b0));
        end
        while (model_locked)
            send_tick();
    endtask

    task automatic run_random(input int beats);
        int          stop_at;
        int unsigned pick;
        int unsigned burst;
        int unsigned noise;
        stop_at = useful_beats + beats;
        while (useful_beats < stop_at)
        begin
            pick = $urandom_range(99);
            if (!model_locked && warn_left != 0 && pick < 75)
            begin
                burst = $urandom_range(1, warn_left);
                repeat (burst) send_tick();
            end
            else if (pick < 40)
                enter_code(model_locked ? lock_cfg.override_code : lock_cfg.user_code);
            else if (pick < 62)
                enter_code(rand_code(1'b1));
            else if (pick < 80)
            begin
                burst = $urandom_range(1, model_locked ? lock_cfg.lockdown_seconds + 1 : 3);
                repeat (burst) send_tick();
            end
            else if (pick < 97)
            begin
                noise = $urandom;
                send_beat(noise[DIGIT_W], noise[DIGIT_W-1:0]);
            end
            else
                drain_results();
        end
    endtask

    task automatic test_random_traffic(input int unsigned send_pct,
                                       input int unsigned recv_pct, input int beats);
        drain_results();
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        repeat (3)
        begin
            write_config(rand_config());
            run_random(beats / 3);
        end
    endtask

    initial
    begin
        result_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            result_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (status_due.size() == 0)
            begin
                $display("%0t: unexpected result beat, expected none, actual event %0d",
                         $time, result_ch.event_res);
                mismatches++;
            end
            else
            begin
                want = status_due.pop_front();
                check_field("event_res", 32'(want.event_res), 32'(result_ch.event_res));
                check_field("locked", 32'(want.locked), 32'(result_ch.locked));
                check_field("failures", 32'(want.failures), 32'(result_ch.failures));
                check_field("lock_events", 32'(want.lock_events),
                            32'(result_ch.lock_events));
                check_field("digits_held", 32'(want.digits_held),
                            32'(result_ch.digits_held));
            end
        end
    end

    initial
    begin
        mismatches    = 0;
        useful_beats  = 0;
        send_idle_pct = 23;
        recv_idle_pct = 51;
        lock_cfg      = make_config(USER_CODE_RST, OVERRIDE_CODE_RST, LOCKDOWN_SEC_RST,
                                    WARNING_SEC_RST);
        for (int i = 0; i < CODE_LEN; i++)
            entry[i] = '0;
        entry_pos    = 0;
        fail_cnt     = '0;
        model_locked = 1'b0;
        lock_age     = '0;
        warn_left    = '0;
        lockdowns    = '0;

        rst_n         <= 1'b0;
        item_ch.valid <= 1'b0;
        item_ch.mode  <= 1'b0;
        item_ch.key   <= '0;
        wr_en         <= 1'b0;
        wr_index      <= REG_USER_CODE;
        wr_data       <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_default_codes();
        test_warning_hold();
        test_lockdown();
        test_zero_hold();
        test_random_traffic(23, 51, 400);
        test_random_traffic(51, 23, 400);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_longest_hold();
        test_random_traffic(0, 0, 400);

        drain_results();
        repeat (8) @(posedge clk);
        if (mismatches == 0 && status_due.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

@@ filelist.f @@
hw/rtl/kcl_pkg.sv
hw/rtl/kcl_if.sv
hw/rtl/kcl_core.sv
hw/rtl/keypad_code_lock_lockout.sv
hw/rtl/kcl_checker.sv
tb/sv/keypad_code_lock_lockout_tb.sv
